[rtl/rmq_pkg.sv]
// Shared constants and types for the rotation matrix to quaternion core.
// Used by the front, queue, back and top modules by scoped name.
package rmq_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int ENTRY_WIDTH = 16;
   localparam int TRANS_W     = 32;

   // raw diagonal sums are signed and never wrap
   localparam int SUM_W   = ((FRAC_BITS + 1 > ENTRY_WIDTH) ? FRAC_BITS + 1 : ENTRY_WIDTH) + 3;
   localparam int CLAMP_W = SUM_W - 1;
   localparam int RAD_W   = CLAMP_W + FRAC_BITS - 2;
   localparam int ROOT_W  = (RAD_W + 1) / 2;
   localparam int RAD2_W  = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 3;

   localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;
   localparam logic [63:0] MAG_LIM = (64'(1) << (ENTRY_WIDTH - 1)) - 64'(1);

   localparam int REQ_W = 9 * ENTRY_WIDTH + 3 * TRANS_W;
   localparam int REQ_BYTES_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W = 4 * ENTRY_WIDTH + 3 * TRANS_W;
   localparam int RSP_BYTES_W = ((RSP_W + 7) / 8) * 8;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   typedef struct packed {
      logic [3:0][CLAMP_W-1:0] sum;   // w, x, y, z
      logic [2:0]              neg;   // x, y, z
      logic [2:0][TRANS_W-1:0] trans;
   } job_type;

   typedef struct packed {
      logic [3:0][RAD2_W-1:0]  rad;
      logic [3:0][REM_W-1:0]   rem;
      logic [3:0][ROOT_W-1:0]  root;
      logic [2:0]              neg;
      logic [2:0][TRANS_W-1:0] trans;
   } stage_type;

endpackage

[rtl/rmq_front.sv]
// Front end: accepts a matrix, forms the clamped diagonal sums and sign flags.
// Depends on rmq_pkg.
module rmq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rmq_pkg::REQ_BYTES_W-1:0] in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rmq_pkg::job_type              out_job
);
   localparam int EW = rmq_pkg::ENTRY_WIDTH;
   localparam int SW = rmq_pkg::SUM_W;

   logic signed [EW-1:0] m [9];
   logic signed [SW-1:0] s [4];
   logic signed [EW:0]   d [3];
   rmq_pkg::job_type job_in, job_ff;
   logic vld_ff, vld_in;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = in_data[i*EW +: EW];
      end
      s[0] = rmq_pkg::ONE_S + SW'(m[0]) + SW'(m[4]) + SW'(m[8]);
      s[1] = rmq_pkg::ONE_S + SW'(m[0]) - SW'(m[4]) - SW'(m[8]);
      s[2] = rmq_pkg::ONE_S - SW'(m[0]) + SW'(m[4]) - SW'(m[8]);
      s[3] = rmq_pkg::ONE_S - SW'(m[0]) - SW'(m[4]) + SW'(m[8]);
      d[0] = (EW+1)'(m[5]) - (EW+1)'(m[7]);
      d[1] = (EW+1)'(m[6]) - (EW+1)'(m[2]);
      d[2] = (EW+1)'(m[1]) - (EW+1)'(m[3]);
      for (int i = 0; i < 4; i++) begin
         // clamp negative sums to zero
         job_in.sum[i] = s[i][SW-1] ? '0 : s[i][rmq_pkg::CLAMP_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         job_in.neg[i]   = d[i][EW];
         job_in.trans[i] = in_data[9*EW + i*rmq_pkg::TRANS_W +: rmq_pkg::TRANS_W];
      end
   end

   assign in_ready  = !vld_ff || out_ready;
   assign vld_in    = in_ready ? in_valid : vld_ff;
   assign out_valid = vld_ff;
   assign out_job   = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end
endmodule

[rtl/rmq_queue.sv]
// Short queue between the front end and the root pipeline.
// Depends on rmq_pkg.
module rmq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rmq_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output rmq_pkg::job_type out_job
);
   rmq_pkg::job_type mem [rmq_pkg::Q_DEPTH];
   logic [rmq_pkg::Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rmq_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != rmq_pkg::Q_CNT_W'(rmq_pkg::Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + rmq_pkg::Q_CNT_W'(push) - rmq_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= in_job;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rmq_pkg::Q_CNT_W'(rmq_pkg::Q_DEPTH)) else $error("queue overfilled");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      rmq_pkg::Q_PTR_W'(wr_ff - rd_ff) == cnt_ff[rmq_pkg::Q_PTR_W-1:0])
      else $error("queue pointers disagree with count");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
`endif
endmodule

[rtl/rmq_back.sv]
// Back end: one root bit per stage for all four components, then saturate and sign.
// Depends on rmq_pkg.
module rmq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  rmq_pkg::job_type                in_job,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [rmq_pkg::RSP_BYTES_W-1:0] out_data
);
   localparam int NS = rmq_pkg::ROOT_W;
   localparam int EW = rmq_pkg::ENTRY_WIDTH;
   localparam int RW = rmq_pkg::REM_W;

   function automatic rmq_pkg::stage_type sqrt_step(rmq_pkg::stage_type s);
      rmq_pkg::stage_type r;
      logic [RW-1:0] lhs, rhs;
      r = s;
      for (int i = 0; i < 4; i++) begin
         lhs = {s.rem[i][RW-3:0], s.rad[i][rmq_pkg::RAD2_W-1 -: 2]};
         rhs = {1'b0, s.root[i], 2'b01};
         r.rad[i] = {s.rad[i][rmq_pkg::RAD2_W-3:0], 2'b00};
         if (lhs >= rhs) begin
            r.rem[i]  = lhs - rhs;
            r.root[i] = {s.root[i][NS-2:0], 1'b1};
         end else begin
            r.rem[i]  = lhs;
            r.root[i] = {s.root[i][NS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   rmq_pkg::stage_type init, st_ff [NS];
   logic [NS:0] vld_ff;
   logic adv;
   logic [rmq_pkg::RSP_BYTES_W-1:0] out_ff, out_in;
   logic [NS-1:0] mag;
   logic [EW-1:0] sat;
   logic [3:0]    sgn;

   // whole pipeline moves unless the output is held
   assign adv       = !vld_ff[NS] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NS];
   assign out_data  = out_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init.rad[i]  = rmq_pkg::RAD2_W'({in_job.sum[i], {(rmq_pkg::FRAC_BITS-2){1'b0}}});
         init.rem[i]  = '0;
         init.root[i] = '0;
      end
      init.neg   = in_job.neg;
      init.trans = in_job.trans;
   end

   always_comb begin
      out_in = '0;
      mag = '0;
      sat = '0;
      // w never takes a sign; x, y, z follow their flags
      sgn = {st_ff[NS-1].neg, 1'b0};
      for (int i = 0; i < 4; i++) begin
         mag = st_ff[NS-1].root[i];
         sat = (64'(mag) > rmq_pkg::MAG_LIM) ? EW'(rmq_pkg::MAG_LIM) : EW'(mag);
         if (sgn[i] && sat != '0) begin
            sat = -sat;
         end
         out_in[i*EW +: EW] = sat;
      end
      for (int i = 0; i < 3; i++) begin
         out_in[4*EW + i*rmq_pkg::TRANS_W +: rmq_pkg::TRANS_W] = st_ff[NS-1].trans[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= sqrt_step(init);
         for (int k = 1; k < NS; k++) begin
            st_ff[k] <= sqrt_step(st_ff[k-1]);
         end
         out_ff <= out_in;
      end
   end
endmodule

[rtl/rotation_matrix_to_quaternion_core.sv]
// Rotation matrix to quaternion core: the top level.
// Ties front end, queue and root pipeline; depends on rmq_pkg and rmq_* modules.
//
// Usage:
//  req_* carries one 3x3 rotation matrix (Q1.14 entries) and a Q16.16
//  translation per transfer; rsp_* returns the quaternion (w, x, y, z,
//  Q1.14, saturated) with the translation passed through unchanged.
//  Every request yields exactly one response, in order.
//  Throughput: one transfer per cycle, sustained while rsp_tready stays
//  high, set by the one-bit-per-stage square root pipeline that all four
//  components share in lockstep.
//  The front register loads at the req transfer edge; the item then passes
//  the queue, the ROOT_W root stages and the output register before
//  rsp_tvalid rises.
//  When rsp_tready drops the root pipeline holds as one piece; the queue
//  between front end and pipeline absorbs requests until full; req_tready
//  falls once the front register fills too. A held response stays stable.
//  Reset (synchronous, active high) empties the pipeline and the queue;
//  no state survives it and none is needed, since items are independent.
module rotation_matrix_to_quaternion_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0 .. m_r2_c2, trans_x_in, trans_y_in,
   // trans_z_in
   input  logic [rmq_pkg::REQ_BYTES_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // quat_w, quat_x, quat_y, quat_z, trans_x_out, trans_y_out, trans_z_out
   output logic [rmq_pkg::RSP_BYTES_W-1:0] rsp_tdata
);
   rmq_pkg::job_type f_job, q_job;
   logic f_valid, f_ready, q_valid, q_ready;

   // classify: sums, clamp and sign flags
   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_job   (f_job)
   );

   // decouple so front and back stall independently
   rmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_job   (q_job)
   );

   // roots, saturation, signs
   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_job    (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );
endmodule
